// File: design/assert_macros.svh
// Assertion helpers shared by the ladder filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define FPLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define FPLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/fpll_pkg.sv
`default_nettype none

package fpll_pkg;

  // Default configuration of the block.
  localparam int CHANNELS_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CHAN_BITS       = 3;
  localparam int COEF_BITS       = 32;
  localparam int CFG_IDX_BITS    = 2;

  // Register reset values, Q8.24.
  localparam int CUTOFF_RESET   = 4410000;
  localparam int FEEDBACK_RESET = 1677000;
  localparam int GAIN_RESET     = 4;

  // The stages use one minus the cutoff coefficient; it is kept in that form.
  localparam logic signed [32:0] OMF_RESET = 33'sd16777216 - 33'(CUTOFF_RESET);

  // 0.3 in Q8.24.
  localparam logic signed [31:0] POINT_THREE = 32'sd5033165;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CUTOFF   = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_GAIN     = 2'd2
  } cfg_reg_t;

  // Operand choice of the shared 32 x 32 multiplier.
  typedef enum logic [1:0] {
    MUL_FB   = 2'd0,
    MUL_GAIN = 2'd1,
    MUL_P3   = 2'd2
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       ld_in;      // latch channel and rescaled sample
    logic       rd_en;      // read the state memory
    logic [1:0] rd_stage;   // stage whose state is read
    logic       m0_en;      // load the 32 x 32 product
    mul_sel_t   m0_sel;
    logic       m1_en;      // load the (1 - f) * y product
    logic       fb_sub;     // subtract the feedback term
    logic       gain_rnd;   // round the gain product into x
    logic       stage_sum;  // finish one stage and write its state
    logic [1:0] wr_stage;
    logic       out_ld;     // load the output register
  } fpll_cmd_t;

  // Saturate a 33-bit value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else begin
      r = {v[32], {31{~v[32]}}};
    end
    return r;
  endfunction

  // Drop 24 fraction bits rounding half up, then saturate to 32 bits.
  function automatic logic signed [31:0] rnd_q24(input logic signed [65:0] v);
    logic signed [65:0] t;
    logic signed [41:0] q;
    logic signed [31:0] r;
    t = v + 66'sd8388608;
    q = t[65:24];
    if ((&q[41:31]) || !(|q[41:31])) begin
      r = q[31:0];
    end else begin
      r = {q[41], {31{~q[41]}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/fpll_in_if.sv
`default_nettype none

// Sample channel into the filter.
interface fpll_in_if
  import fpll_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [CHAN_BITS-1:0]          chan;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output chan, output sample_in, input ready);
  modport sink   (input valid, input chan, input sample_in, output ready);
endinterface

`default_nettype wire

// File: design/fpll_out_if.sv
`default_nettype none

// Filtered sample channel out of the filter.
interface fpll_out_if
  import fpll_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CHAN_BITS-1:0]          out_chan;

  modport source (output valid, output sample_out, output out_chan, input ready);
  modport sink   (input valid, input sample_out, input out_chan, output ready);
endinterface

`default_nettype wire

// File: design/fpll_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module fpll_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end
endmodule

`default_nettype wire

// File: design/fpll_ctrl.sv
`default_nettype none

// Sequencer: walks one item through feedback, gain and the four stages.
module fpll_ctrl
  import fpll_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire logic      chan_ok,
  output fpll_cmd_t      cmd
);
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_FBMUL,
    S_FBSUB,
    S_GMUL,
    S_GRND,
    S_STAGE,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] stg_r, stg_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commands and next state.
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    stg_nxt       = stg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // Fetch the last fourth-stage output for the feedback term.
          cmd.ld_in    = 1'b1;
          cmd.rd_en    = 1'b1;
          cmd.rd_stage = 2'd3;
          state_nxt    = S_FBMUL;
        end
      end
      S_FBMUL: begin
        if (chan_ok) begin
          cmd.m0_en  = 1'b1;
          cmd.m0_sel = MUL_FB;
          state_nxt  = S_FBSUB;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FBSUB: begin
        cmd.fb_sub = 1'b1;
        state_nxt  = S_GMUL;
      end
      S_GMUL: begin
        cmd.m0_en    = 1'b1;
        cmd.m0_sel   = MUL_GAIN;
        cmd.rd_en    = 1'b1;
        cmd.rd_stage = 2'd0;
        state_nxt    = S_GRND;
      end
      S_GRND: begin
        // Gain rounding overlaps the state products of the first stage.
        cmd.gain_rnd = 1'b1;
        cmd.m0_en    = 1'b1;
        cmd.m0_sel   = MUL_P3;
        cmd.m1_en    = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_stage = 2'd1;
        stg_nxt      = 2'd0;
        state_nxt    = S_STAGE;
      end
      S_STAGE: begin
        // Stage stg_r finishes while the next stage forms its products.
        cmd.stage_sum = 1'b1;
        cmd.wr_stage  = stg_r;
        if (stg_r != 2'd3) begin
          cmd.m0_en  = 1'b1;
          cmd.m0_sel = MUL_P3;
          cmd.m1_en  = 1'b1;
        end
        if (stg_r < 2'd2) begin
          cmd.rd_en    = 1'b1;
          cmd.rd_stage = stg_r + 2'd2;
        end
        if (stg_r == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          stg_nxt = stg_r + 2'd1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered handshake outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stg_r       <= stg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FPLL_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "second item taken early")
  `FPLL_ASSERT(a_result_from_out, $rose(out_valid_r) |-> $past(state_r == S_OUT), "stray result")
  `FPLL_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r, "result valid after reset")
endmodule

`default_nettype wire

// File: design/fpll_dp.sv
`default_nettype none

// Datapath: coefficient registers, state memory, two multipliers, rounding.
module fpll_dp
  import fpll_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fpll_cmd_t                     cmd,
  output logic                               chan_ok,
  input  wire logic [CHAN_BITS-1:0]          in_chan,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_idx,
  input  wire logic [COEF_BITS-1:0]          cfg_wdata,
  output logic signed [SAMPLE_BITS-1:0]      sample_out,
  output logic [CHAN_BITS-1:0]               out_chan
);
  `include "assert_macros.svh"

  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = CHANNELS * 4;
  localparam int AW    = $clog2(DEPTH);

  // Coefficients; the cutoff is held as one minus f.
  logic signed [32:0] omf_r;
  logic signed [31:0] fb_r;
  logic signed [31:0] gain_r;

  logic [CHAN_BITS-1:0]   chan_r;
  logic                   zero_r;
  logic signed [31:0]     x_r;
  logic signed [63:0]     p0_r;
  logic signed [64:0]     p1_r;
  logic [CHANNELS-1:0]    vld_r;
  logic signed [SAMPLE_BITS-1:0] sample_out_r;
  logic [CHAN_BITS-1:0]   out_chan_r;

  logic [CH_W-1:0]        chan_idx;
  logic [CHAN_BITS-1:0]   rd_chan;
  logic                   in_ok;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [63:0]            rd_data;
  logic signed [31:0]     mem_x;
  logic signed [31:0]     mem_y;
  logic signed [31:0]     m0_a;
  logic signed [31:0]     m0_b;
  logic signed [31:0]     x0;
  logic signed [31:0]     y_new;
  logic signed [SAMPLE_BITS-1:0] o_sat;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      omf_r  <= OMF_RESET;
      fb_r   <= 32'(FEEDBACK_RESET);
      gain_r <= 32'(GAIN_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CUTOFF:   omf_r  <= 33'sd16777216 - 33'(signed'(cfg_wdata));
        REG_FEEDBACK: fb_r   <= signed'(cfg_wdata);
        REG_GAIN:     gain_r <= signed'(cfg_wdata);
        default:      ;
      endcase
    end
  end

  // Input sample rescaled to Q9.23.
  generate
    if (SAMPLE_BITS <= 24) begin : g_in_up
      assign x0 = 32'(in_sample) <<< (24 - SAMPLE_BITS);
    end else begin : g_in_dn
      localparam int RS  = SAMPLE_BITS - 24;
      localparam int SW1 = SAMPLE_BITS + 1;
      logic signed [SW1-1:0] t;
      assign t  = (SW1'(in_sample) + SW1'(1 << (RS - 1))) >>> RS;
      assign x0 = 32'(t);
    end
  endgenerate

  // State memory addressing; the feedback read uses the arriving channel.
  assign rd_chan  = cmd.ld_in ? in_chan : chan_r;
  assign chan_idx = CH_W'(chan_r);
  assign in_ok    = (int'(in_chan) < CHANNELS);
  assign rd_addr  = AW'({CH_W'(rd_chan), cmd.rd_stage});
  assign wr_addr  = AW'({chan_idx, cmd.wr_stage});

  fpll_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_state (
    .clk     (clk),
    .wr_en   (cmd.stage_sum),
    .wr_addr (wr_addr),
    .wr_data ({x_r, y_new}),
    .rd_en   (cmd.rd_en && (!cmd.ld_in || in_ok)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // A channel never written since reset reads as zero state.
  assign mem_x = vld_r[chan_idx] ? signed'(rd_data[63:32]) : 32'sd0;
  assign mem_y = vld_r[chan_idx] ? signed'(rd_data[31:0])  : 32'sd0;

  // Operand selection of the shared multiplier.
  always_comb begin
    case (cmd.m0_sel)
      MUL_FB: begin
        m0_a = mem_y;
        m0_b = fb_r;
      end
      MUL_GAIN: begin
        m0_a = x_r;
        m0_b = gain_r;
      end
      MUL_P3: begin
        m0_a = POINT_THREE;
        m0_b = mem_x;
      end
      default: begin
        m0_a = 32'sd0;
        m0_b = 32'sd0;
      end
    endcase
  end

  // Stage result: x + 0.3 * x_prev + (1 - f) * y at 24 fraction bits.
  assign y_new = rnd_q24((66'(x_r) <<< 24) + 66'(p0_r) + 66'(p1_r));

  // Output rescale from Q9.23 to the sample format, then saturation.
  generate
    if (SAMPLE_BITS >= 24) begin : g_out_up
      localparam int OW = 32 + SAMPLE_BITS - 24;
      logic signed [OW-1:0] o_w;
      assign o_w   = OW'(x_r) <<< (SAMPLE_BITS - 24);
      assign o_sat = ((&o_w[OW-1:SAMPLE_BITS-1]) || !(|o_w[OW-1:SAMPLE_BITS-1]))
                     ? o_w[SAMPLE_BITS-1:0]
                     : {o_w[OW-1], {(SAMPLE_BITS-1){~o_w[OW-1]}}};
    end else begin : g_out_dn
      localparam int RS = 24 - SAMPLE_BITS;
      logic signed [32:0] o_w;
      assign o_w   = (33'(x_r) + 33'(1 << (RS - 1))) >>> RS;
      assign o_sat = ((&o_w[32:SAMPLE_BITS-1]) || !(|o_w[32:SAMPLE_BITS-1]))
                     ? o_w[SAMPLE_BITS-1:0]
                     : {o_w[32], {(SAMPLE_BITS-1){~o_w[32]}}};
    end
  endgenerate

  // Channel validity marks; a channel's row is complete once its stages ran.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.stage_sum && (cmd.wr_stage == 2'd3)) begin
      vld_r[chan_idx] <= 1'b1;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      chan_r <= in_chan;
      zero_r <= !in_ok;
      x_r    <= x0;
    end else if (cmd.fb_sub) begin
      x_r <= sat32(33'(x_r) - 33'(rnd_q24(66'(p0_r))));
    end else if (cmd.gain_rnd) begin
      x_r <= rnd_q24(66'(p0_r));
    end else if (cmd.stage_sum) begin
      x_r <= y_new;
    end
    if (cmd.m0_en) begin
      p0_r <= m0_a * m0_b;
    end
    if (cmd.m1_en) begin
      p1_r <= omf_r * mem_y;
    end
    if (cmd.out_ld) begin
      sample_out_r <= zero_r ? '0 : o_sat;
      out_chan_r   <= chan_r;
    end
  end

  assign chan_ok    = !zero_r;
  assign sample_out = sample_out_r;
  assign out_chan   = out_chan_r;

  `FPLL_ASSERT(a_no_write_bad_chan, cmd.stage_sum |-> !zero_r, "state write for absent channel")
  `FPLL_ASSERT(a_out_after_stage4, (cmd.out_ld && !zero_r) |-> vld_r[chan_idx], "early output")
endmodule

`default_nettype wire

// File: design/four_pole_ladder_lowpass_top.sv
`default_nettype none

// Multichannel resonant four-pole ladder lowpass. Each item carries a channel
// number and a signed sample; the block subtracts feedback_coef times that
// channel's last fourth-stage output, scales by input_gain, runs four one-pole
// stages y = x + 0.3 * x_prev + (1 - cutoff_coef) * y and returns the rounded,
// saturated fourth-stage output with its channel. Coefficients are Q8.24 and
// are written through cfg_we / cfg_idx / cfg_wdata; the user must write them
// only while the block is idle, as the block itself does not enforce it. A
// new item is taken only once the last one has left the sequencer, which
// shares two multipliers across the ten products and reads the per-channel
// stage state from one read port of the state RAM. A channel number at or
// above CHANNELS skips feedback, gain and the stages, has a zero result
// presented, and state is left alone. While an earlier result still waits
// at the output, the sequencer holds the finished item until that result is
// taken.
// The state RAM needs no clearing pass after reset: per-channel valid marks
// make untouched channels read as zero.
module four_pole_ladder_lowpass_top
  import fpll_pkg::*;
#(
  parameter int CHANNELS    = CHANNELS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  fpll_in_if.sink                      in_ch,
  fpll_out_if.source                   out_ch,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  wire logic [COEF_BITS-1:0]    cfg_wdata
);
  fpll_cmd_t cmd;
  logic      chan_ok;

  // Sequencer.
  fpll_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .chan_ok   (chan_ok),
    .cmd       (cmd)
  );

  // Arithmetic and state.
  fpll_dp #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .chan_ok    (chan_ok),
    .in_chan    (in_ch.chan),
    .in_sample  (in_ch.sample_in),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .sample_out (out_ch.sample_out),
    .out_chan   (out_ch.out_chan)
  );
endmodule

`default_nettype wire
